@@ hw/rtl/per_address_median_range_filter_defines.svh @@
// Assertion macros shared by the per-address median range filter RTL
`ifndef PER_ADDRESS_MEDIAN_RANGE_FILTER_DEFINES_SVH
`define PER_ADDRESS_MEDIAN_RANGE_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define PAMRF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset
`define PAMRF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/pamrf_pkg.sv @@
// Package: sizes, payload types and slot command for the median range filter
`default_nettype none

package pamrf_pkg;

	localparam int WINDOW  = 5;
	localparam int SLOTS   = 8;
	localparam int TAG_W   = 16;
	localparam int RANGE_W = 24;
	localparam int HELD_W  = 3;

	localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FILL_W  = $clog2(WINDOW + 1);
	localparam int DEPTH   = SLOTS * WINDOW;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef struct packed {
		logic [TAG_W-1:0]          peer_addr;
		logic signed [RANGE_W-1:0] range_mm;
	} item_t;

	typedef struct packed {
		logic signed [RANGE_W-1:0] median_range_mm;
		logic [HELD_W-1:0]         samples_held;
	} result_t;

	// Slot decision handed from the slot table to the median unit
	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [POS_W-1:0]  pos;
		logic [FILL_W-1:0] fill;
	} slot_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/pamrf_slots.sv @@
// Slot table: owner, fill and ring position per slot, with a one-slot-per-cycle search
`default_nettype none

module pamrf_slots (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        go,
	input  wire logic [pamrf_pkg::TAG_W-1:0] tag,
	output logic                             done,
	output pamrf_pkg::slot_cmd_t             cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;

	logic [pamrf_pkg::TAG_W-1:0]  owner_q [pamrf_pkg::SLOTS];
	logic [pamrf_pkg::FILL_W-1:0] fill_q  [pamrf_pkg::SLOTS];
	logic [pamrf_pkg::POS_W-1:0]  wp_q    [pamrf_pkg::SLOTS];

	logic [1:0]                   state_q;
	logic [pamrf_pkg::TAG_W-1:0]  addr_q;
	logic [pamrf_pkg::SLOT_W-1:0] idx_q;
	logic                         hit_q;
	logic [pamrf_pkg::SLOT_W-1:0] hit_idx_q;
	logic [pamrf_pkg::FILL_W-1:0] hit_fill_q;
	logic [pamrf_pkg::POS_W-1:0]  hit_wp_q;
	logic                         emp_q;
	logic [pamrf_pkg::SLOT_W-1:0] emp_idx_q;
	logic                         done_q;
	pamrf_pkg::slot_cmd_t         cmd_q;

	logic                         occ;
	logic                         match;
	logic [pamrf_pkg::SLOT_W-1:0] sel;
	logic [pamrf_pkg::FILL_W-1:0] base_fill;
	logic [pamrf_pkg::POS_W-1:0]  pos;
	logic [pamrf_pkg::POS_W-1:0]  new_wp;
	logic [pamrf_pkg::FILL_W-1:0] new_fill;

	// Compare the slot under the scan index against the address
	assign occ   = (fill_q[idx_q] != '0);
	assign match = occ && (owner_q[idx_q] == addr_q);

	// Pick the slot: matching one, else first empty, else evict slot 0
	always_comb begin
		if (hit_q) begin
			sel       = hit_idx_q;
			base_fill = hit_fill_q;
			pos       = hit_wp_q;
		end else begin
			sel       = emp_q ? emp_idx_q : '0;
			base_fill = '0;
			pos       = '0;
		end
		new_wp   = (pos == pamrf_pkg::POS_W'(pamrf_pkg::WINDOW - 1)) ? '0
			: pos + pamrf_pkg::POS_W'(1);
		new_fill = (base_fill >= pamrf_pkg::FILL_W'(pamrf_pkg::WINDOW))
			? pamrf_pkg::FILL_W'(pamrf_pkg::WINDOW) : base_fill + pamrf_pkg::FILL_W'(1);
	end

	// Sequence the search and commit the slot update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pamrf_pkg::SLOTS; i++) begin
				owner_q[i] <= '0;
				fill_q[i]  <= '0;
				wp_q[i]    <= '0;
			end
			state_q    <= S_IDLE;
			addr_q     <= '0;
			idx_q      <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			hit_fill_q <= '0;
			hit_wp_q   <= '0;
			emp_q      <= 1'b0;
			emp_idx_q  <= '0;
			done_q     <= 1'b0;
			cmd_q      <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (go) begin
						addr_q  <= tag;
						idx_q   <= '0;
						hit_q   <= 1'b0;
						emp_q   <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (match) begin
						hit_q      <= 1'b1;
						hit_idx_q  <= idx_q;
						hit_fill_q <= fill_q[idx_q];
						hit_wp_q   <= wp_q[idx_q];
						state_q    <= S_COMMIT;
					end else begin
						if (!occ && !emp_q) begin
							emp_q     <= 1'b1;
							emp_idx_q <= idx_q;
						end
						if (idx_q == pamrf_pkg::SLOT_W'(pamrf_pkg::SLOTS - 1)) begin
							state_q <= S_COMMIT;
						end else begin
							idx_q <= idx_q + pamrf_pkg::SLOT_W'(1);
						end
					end
				end
				S_COMMIT: begin
					owner_q[sel] <= addr_q;
					fill_q[sel]  <= new_fill;
					wp_q[sel]    <= new_wp;
					cmd_q.slot   <= sel;
					cmd_q.pos    <= pos;
					cmd_q.fill   <= new_fill;
					done_q       <= 1'b1;
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done = done_q;
	assign cmd  = cmd_q;

endmodule

`default_nettype wire

@@ hw/rtl/pamrf_median.sv @@
// Sample memory and rank-count median unit with one shared signed comparator
`default_nettype none

module pamrf_median (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                go,
	input  wire pamrf_pkg::slot_cmd_t                cmd,
	input  wire logic signed [pamrf_pkg::RANGE_W-1:0] sample,
	output logic                                     done,
	output logic signed [pamrf_pkg::RANGE_W-1:0]     median
);

	localparam logic [2:0] M_IDLE = 3'd0;
	localparam logic [2:0] M_LOAD = 3'd1;
	localparam logic [2:0] M_PICK = 3'd2;
	localparam logic [2:0] M_CMP  = 3'd3;
	localparam logic [2:0] M_CHK  = 3'd4;

	logic signed [pamrf_pkg::RANGE_W-1:0] mem_q [pamrf_pkg::DEPTH];
	logic signed [pamrf_pkg::RANGE_W-1:0] rdata_q;
	logic signed [pamrf_pkg::RANGE_W-1:0] buf_q [pamrf_pkg::WINDOW];
	logic signed [pamrf_pkg::RANGE_W-1:0] cand_q;
	logic signed [pamrf_pkg::RANGE_W-1:0] median_q;

	logic [2:0]                   state_q;
	logic [pamrf_pkg::ADDR_W-1:0] base_q;
	logic [pamrf_pkg::FILL_W-1:0] n_q;
	logic [pamrf_pkg::FILL_W-1:0] rd_q;
	logic                         rv_q;
	logic                         rl_q;
	logic [pamrf_pkg::FILL_W-1:0] k_q;
	logic [pamrf_pkg::FILL_W-1:0] lt_q;
	logic [pamrf_pkg::FILL_W-1:0] le_q;
	logic                         done_q;

	logic [pamrf_pkg::ADDR_W-1:0] wr_addr;
	logic [pamrf_pkg::ADDR_W-1:0] go_base;
	logic                         rd_en;
	logic [pamrf_pkg::FILL_W-1:0] last_idx;
	logic [pamrf_pkg::FILL_W-1:0] mid;
	logic                         cmp_lt;
	logic                         cmp_eq;
	logic                         found;
	logic                         shift_en;
	logic signed [pamrf_pkg::RANGE_W-1:0] shift_in;

	// Address the slot's ring inside the flat sample memory
	assign go_base = pamrf_pkg::ADDR_W'(cmd.slot) * pamrf_pkg::ADDR_W'(pamrf_pkg::WINDOW);
	assign wr_addr = go_base + pamrf_pkg::ADDR_W'(cmd.pos);

	assign rd_en    = (state_q == M_LOAD) && (rd_q != n_q);
	assign last_idx = n_q - pamrf_pkg::FILL_W'(1);
	assign mid      = n_q >> 1;

	// Shared comparator: ring head against the candidate
	assign cmp_lt = (buf_q[0] < cand_q);
	assign cmp_eq = (buf_q[0] == cand_q);

	// Candidate is the median when the target rank falls inside its tie range
	assign found = (lt_q <= mid) && (mid < le_q);

	assign shift_en = ((state_q == M_LOAD) && rv_q) || (state_q == M_CMP)
		|| ((state_q == M_CHK) && !found);
	assign shift_in = (state_q == M_LOAD) ? rdata_q : buf_q[0];

	// Write the new sample, read the ring one entry a cycle
	always_ff @(posedge clk) begin
		if (go) begin
			mem_q[wr_addr] <= sample;
		end
		rdata_q <= mem_q[base_q + pamrf_pkg::ADDR_W'(rd_q)];
	end

	// Shift samples in at the ring tail, or rotate the ring
	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int k = 0; k < pamrf_pkg::WINDOW; k++) begin
				if (pamrf_pkg::FILL_W'(k) == last_idx) begin
					buf_q[k] <= shift_in;
				end else if (pamrf_pkg::FILL_W'(k) < last_idx) begin
					buf_q[k] <= buf_q[(k + 1) % pamrf_pkg::WINDOW];
				end
			end
		end
	end

	// Sequence load, candidate pick, rank count and check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= M_IDLE;
			base_q   <= '0;
			n_q      <= '0;
			rd_q     <= '0;
			rv_q     <= 1'b0;
			rl_q     <= 1'b0;
			k_q      <= '0;
			lt_q     <= '0;
			le_q     <= '0;
			cand_q   <= '0;
			median_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			rv_q   <= rd_en;
			rl_q   <= rd_en && (rd_q == last_idx);
			if (rd_en) begin
				rd_q <= rd_q + pamrf_pkg::FILL_W'(1);
			end
			case (state_q)
				M_IDLE: begin
					if (go) begin
						base_q  <= go_base;
						n_q     <= cmd.fill;
						rd_q    <= '0;
						state_q <= M_LOAD;
					end
				end
				M_LOAD: begin
					if (rv_q && rl_q) begin
						state_q <= M_PICK;
					end
				end
				M_PICK: begin
					cand_q  <= buf_q[0];
					lt_q    <= '0;
					le_q    <= '0;
					k_q     <= '0;
					state_q <= M_CMP;
				end
				M_CMP: begin
					lt_q <= lt_q + pamrf_pkg::FILL_W'(cmp_lt);
					le_q <= le_q + pamrf_pkg::FILL_W'(cmp_lt | cmp_eq);
					k_q  <= k_q + pamrf_pkg::FILL_W'(1);
					if (k_q == last_idx) begin
						state_q <= M_CHK;
					end
				end
				M_CHK: begin
					if (found) begin
						median_q <= cand_q;
						done_q   <= 1'b1;
						state_q  <= M_IDLE;
					end else begin
						state_q <= M_PICK;
					end
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign median = median_q;

endmodule

`default_nettype wire

@@ hw/rtl/per_address_median_range_filter.sv @@
// The result strobe rises once the slot search has stepped through the slots to a match or
// the last slot and the median unit has loaded the held samples, then picked and rank-counted
// candidates until one is the median. busy falls with the strobe, so the next transaction can
// be taken while the strobe is high; none is taken before the last result is out, and the
// slot scan and the shared comparator set how long each takes.
// The result strobe lasts one cycle and cannot be stalled. Reset clears every slot.
`default_nettype none

`include "per_address_median_range_filter_defines.svh"

module per_address_median_range_filter (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire pamrf_pkg::item_t  item,
	output logic                   busy,
	output logic                   done,
	output pamrf_pkg::result_t     result
);

	localparam logic [1:0] T_IDLE = 2'd0;
	localparam logic [1:0] T_SRCH = 2'd1;
	localparam logic [1:0] T_MED  = 2'd2;

	logic [1:0]                         state_q;
	pamrf_pkg::item_t                   item_q;
	logic [pamrf_pkg::HELD_W-1:0]       held_q;
	pamrf_pkg::result_t                 result_q;
	logic                               done_q;

	logic                               accept;
	logic                               slots_done;
	pamrf_pkg::slot_cmd_t               slots_cmd;
	logic                               med_done;
	logic signed [pamrf_pkg::RANGE_W-1:0] med_value;

	assign accept = start && !busy;
	assign busy   = (state_q != T_IDLE);

	pamrf_slots u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (accept),
		.tag    (item.peer_addr),
		.done   (slots_done),
		.cmd    (slots_cmd)
	);

	pamrf_median u_median (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (slots_done),
		.cmd    (slots_cmd),
		.sample (item_q.range_mm),
		.done   (med_done),
		.median (med_value)
	);

	// Hold the transaction and step through search and median
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= T_IDLE;
			item_q   <= '0;
			held_q   <= '0;
			result_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						item_q  <= item;
						state_q <= T_SRCH;
					end
				end
				T_SRCH: begin
					if (slots_done) begin
						held_q  <= pamrf_pkg::HELD_W'(slots_cmd.fill);
						state_q <= T_MED;
					end
				end
				T_MED: begin
					if (med_done) begin
						result_q.median_range_mm <= med_value;
						result_q.samples_held    <= held_q;
						done_q                   <= 1'b1;
						state_q                  <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// Check the sequencing between the two units and the port strobe
	`PAMRF_ASSERT_NEXT(a_accept_busy, accept, busy && !done, "busy not raised after transaction")
	`PAMRF_ASSERT_NOW(a_slots_in_search, slots_done, state_q == T_SRCH, "slot result out of search")
	`PAMRF_ASSERT_NEXT(a_median_to_done, med_done && state_q == T_MED, done && !busy, "result lost")
	`PAMRF_ASSERT_NEXT(a_single_strobe, done, !done, "result strobe longer than a cycle")

endmodule

`default_nettype wire

@@ tb/per_address_median_range_filter_checker.sv @@
// Checker: predicts the filtered median for each reading and compares the result stream
module per_address_median_range_filter_checker
	import pamrf_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire logic    busy,
	input  wire item_t   item,
	input  wire logic    done,
	input  wire result_t result,
	output int           mismatches,
	output int           outstanding,
	output int           medians_checked,
	output int           evictions
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow copy of the slot table
	logic [TAG_W-1:0]          owner [SLOTS];
	int unsigned               fill  [SLOTS];
	int unsigned               wpos  [SLOTS];
	logic signed [RANGE_W-1:0] ring  [SLOTS][WINDOW];

	result_t median_queue [$];

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $realtime, msg);
		mismatches++;
	endtask

	// File one reading into its slot and work out the median it yields
	function automatic result_t file_reading(input item_t rd);
		int                        slot;
		int                        s;
		int                        i;
		int                        j;
		int unsigned               n;
		logic signed [RANGE_W-1:0] sorted [WINDOW];
		logic signed [RANGE_W-1:0] key;
		result_t                   res;
		slot = -1;
		// match an occupied slot first
		for (s = 0; s < SLOTS; s++)
			if (slot < 0 && fill[s] != 0 && owner[s] == rd.peer_addr)
				slot = s;
		// otherwise claim the lowest empty slot
		for (s = 0; s < SLOTS; s++)
			if (slot < 0 && fill[s] == 0) begin
				slot    = s;
				owner[s] = rd.peer_addr;
				wpos[s]  = 0;
			end
		// table full: evict slot 0
		if (slot < 0) begin
			slot     = 0;
			owner[0] = rd.peer_addr;
			fill[0]  = 0;
			wpos[0]  = 0;
			evictions++;
		end
		if (wpos[slot] >= WINDOW)
			wpos[slot] = 0;
		ring[slot][wpos[slot]] = rd.range_mm;
		wpos[slot] = (wpos[slot] + 1) % WINDOW;
		if (fill[slot] < WINDOW)
			fill[slot]++;
		n = fill[slot];
		// insertion sort of the held samples, signed
		for (i = 0; i < n; i++)
			sorted[i] = ring[slot][i];
		for (i = 1; i < n; i++) begin
			key = sorted[i];
			j   = i;
			while (j > 0 && sorted[j-1] > key) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = key;
		end
		res.median_range_mm = sorted[n/2];
		res.samples_held    = n[HELD_W-1:0];
		return res;
	endfunction

	// Check results against the oldest prediction, then predict for new transactions
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int k = 0; k < SLOTS; k++) begin
				owner[k] = '0;
				fill[k]  = 0;
				wpos[k]  = 0;
			end
			median_queue.delete();
			outstanding <= 0;
		end else begin
			if (done) begin
				if (median_queue.size() == 0) begin
					report_mismatch($sformatf("result (median %0d, held %0d) with none outstanding",
						result.median_range_mm, result.samples_held));
				end else begin
					want = median_queue.pop_front();
					medians_checked++;
					if (result.median_range_mm !== want.median_range_mm)
						report_mismatch($sformatf("median_range_mm: got %0d, expected %0d",
							result.median_range_mm, want.median_range_mm));
					if (result.samples_held !== want.samples_held)
						report_mismatch($sformatf("samples_held: got %0d, expected %0d",
							result.samples_held, want.samples_held));
				end
			end
			if (start && !busy)
				median_queue.push_back(file_reading(item));
			outstanding <= median_queue.size();
		end
	end

endmodule

@@ tb/tb_per_address_median_range_filter.sv @@
// Testbench top: drives tagged range readings into the filter and reports the verdict
module tb_per_address_median_range_filter;
	timeunit 1ns;
	timeprecision 1ps;
	import pamrf_pkg::*;

	localparam int RANDOM_READINGS = 650;
	localparam int TAIL_CYCLES     = 64;

	logic    clk;
	logic    arst_n;
	logic    start;
	item_t   item;
	logic    busy;
	logic    done;
	result_t result;

	int mismatches;
	int outstanding;
	int medians_checked;
	int evictions;
	int readings_sent;
	int directed_sent;

	// addresses that own slots 1..7 once the table has filled
	logic [TAG_W-1:0] resident [7] = '{16'hFFFF, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6};
	logic [TAG_W-1:0] last_fresh = 16'h1234;

	per_address_median_range_filter u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	per_address_median_range_filter_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.item            (item),
		.done            (done),
		.result          (result),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.medians_checked (medians_checked),
		.evictions       (evictions)
	);

	// 8 ns clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hold one reading until accepted, then idle now and again
	task automatic send_reading(input logic [TAG_W-1:0] addr,
	                            input logic signed [RANGE_W-1:0] rng);
		start <= 1'b1;
		item  <= '{peer_addr: addr, range_mm: rng};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		readings_sent++;
		// keep a quiet stretch with no idling in the middle of the random part
		if (!(readings_sent >= 320 && readings_sent < 440) && $urandom_range(99) < 23) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 60))
				@(posedge clk);
		end
	endtask

	function automatic logic [TAG_W-1:0] pick_address();
		int roll;
		roll = $urandom_range(99);
		if (roll < 55)
			return resident[$urandom_range(6)];
		if (roll < 75)
			return last_fresh;
		last_fresh = TAG_W'($urandom());
		return last_fresh;
	endfunction

	function automatic logic signed [RANGE_W-1:0] pick_range();
		int roll;
		int near;
		roll = $urandom_range(99);
		near = int'($urandom_range(40)) - 20;
		if (roll < 35)
			return near[RANGE_W-1:0];
		if (roll < 45)
			case ($urandom_range(3))
				0: return {1'b1, {(RANGE_W-1){1'b0}}};
				1: return {1'b0, {(RANGE_W-1){1'b1}}};
				2: return '1;
				default: return '0;
			endcase
		return RANGE_W'($urandom());
	endfunction

	// Stimulus and verdict
	initial begin
		start  = 1'b0;
		item   = '0;
		arst_n = 1'b0;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill slot 0 past its window with extremes and an even count on the way
		send_reading(16'h0000, 24'sd0);
		send_reading(16'h0000, -24'sd8388608);
		send_reading(16'h0000, 24'sd8388607);
		send_reading(16'h0000, -24'sd1);
		send_reading(16'h0000, 24'sd1);
		send_reading(16'h0000, 24'sd5);
		// all-ones address, ties
		send_reading(16'hFFFF, 24'sd100);
		send_reading(16'hFFFF, 24'sd100);
		// claim every remaining slot
		for (int a = 1; a <= 6; a++)
			send_reading(resident[a], pick_range());
		// table full: each new owner evicts slot 0
		send_reading(16'h1234, -24'sd50);
		send_reading(16'h0000, 24'sd7);
		send_reading(16'h1234, 24'sd8388607);
		send_reading(16'h1234, -24'sd8388608);
		// hits on a resident slot after the evictions
		send_reading(16'hFFFF, 24'sd100);
		send_reading(16'hFFFF, -24'sd100);
		send_reading(16'hFFFF, 24'sd100);
		send_reading(16'hFFFF, 24'sd0);
		directed_sent = readings_sent;

		for (int n = 0; n < RANDOM_READINGS; n++)
			send_reading(pick_address(), pick_range());
		start <= 1'b0;

		// drain, then watch for stray results
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES)
			@(posedge clk);

		$display("Sent %0d readings (%0d directed) and checked %0d medians",
			readings_sent, directed_sent, medians_checked);
		$display("Slot 0 was evicted %0d times by new addresses", evictions);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Timed out with %0d results outstanding", outstanding);
		$display("Mismatches found");
		$finish;
	end

endmodule
